>>> hw/rtl/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared types, register indexes and curve constants for the charge level
// estimator.
// ----------------------------------------------------------------------------
package bcle_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER_RATIO     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_TRIM         = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_OFFSET     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT_THRESHOLD = 4'd3;

    localparam logic [2:0]  DIVIDER_RATIO_RST     = 3'd2;
    localparam logic [10:0] GAIN_TRIM_RST         = 11'd987;
    localparam logic [7:0]  CHARGE_OFFSET_RST     = 8'd55;
    localparam logic [12:0] PRESENT_THRESHOLD_RST = 13'd2800;

    // Scaling: sense*divider*trim/1000, saturated to 15 bits
    localparam logic [25:0] SAT_LIMIT   = 26'd32768000;  // 32768 * 1000
    localparam logic [25:0] RECIP_1000  = 26'd34359738;  // floor(2^35 / 1000)
    localparam int          RECIP_SHIFT = 35;
    localparam logic [14:0] AVG_MAX     = 15'h7FFF;

    // Interpolation divide by 100
    localparam logic [9:0]  RECIP_100   = 10'd655;       // floor(2^16 / 100)
    localparam int          RECIP100_SH = 16;

    // Level constants
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [6:0]  PCT_CHG_CAP = 7'd99;
    localparam logic [6:0]  PCT_EMPTY   = 7'd0;
    localparam logic [12:0] CURVE_TOP   = 13'd4200;

    // Curve segments, highest first. Each segment covers [lo, lo+100) and
    // rises by slope percent over it; the bottom segment spans 200 mV and
    // rises 2, which is the same as slope 1 per 100 mV.
    localparam int NUM_SEG = 11;
    localparam logic [12:0] SEG_LO [NUM_SEG] = '{
        13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700, 13'd3600,
        13'd3500, 13'd3400, 13'd3300, 13'd3200, 13'd3000
    };
    localparam logic [6:0] SEG_PLO [NUM_SEG] = '{
        7'd90, 7'd80, 7'd70, 7'd60, 7'd45, 7'd30, 7'd18, 7'd10, 7'd5, 7'd2, 7'd0
    };
    localparam logic [3:0] SEG_SLOPE [NUM_SEG] = '{
        4'd10, 4'd10, 4'd10, 4'd10, 4'd15, 4'd15, 4'd12, 4'd8, 4'd5, 4'd3, 4'd1
    };

    typedef struct packed {
        logic [11:0] sense_mv;
        logic        sample_ok;
        logic        charging;
        logic        charge_full;
    } bcle_in_t;

    typedef struct packed {
        logic        cell_present;
        logic [6:0]  level_pct;
        logic [14:0] average_mv;
    } bcle_out_t;

    typedef struct packed {
        logic [2:0]  divider_ratio;
        logic [10:0] gain_trim_permille;
        logic [7:0]  charge_offset_mv;
        logic [12:0] present_threshold_mv;
    } bcle_cfg_t;

    // Sequencer commands, one per datapath step
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic recip;
        logic corr;
        logic avg;
        logic lvl1;
        logic lvl2;
        logic lvl3;
        logic fin;
    } bcle_cmd_t;

    typedef struct packed {
        logic reading_ok;
    } bcle_status_t;

endpackage

>>> hw/rtl/bcle_cfg.sv
// ----------------------------------------------------------------------------
// bcle_cfg
// Configuration register file, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module bcle_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcle_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bcle_pkg::bcle_cfg_t              cfg
);
    import bcle_pkg::*;

    bcle_cfg_t cfg_reg;
    bcle_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIVIDER_RATIO:     cfg_next.divider_ratio        = cfg_data[2:0];
                CFG_GAIN_TRIM:         cfg_next.gain_trim_permille   = cfg_data[10:0];
                CFG_CHARGE_OFFSET:     cfg_next.charge_offset_mv     = cfg_data[7:0];
                CFG_PRESENT_THRESHOLD: cfg_next.present_threshold_mv = cfg_data[12:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.divider_ratio        <= DIVIDER_RATIO_RST;
            cfg_reg.gain_trim_permille   <= GAIN_TRIM_RST;
            cfg_reg.charge_offset_mv     <= CHARGE_OFFSET_RST;
            cfg_reg.present_threshold_mv <= PRESENT_THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/bcle_ctrl.sv
// ----------------------------------------------------------------------------
// bcle_ctrl
// Sequencer: steps the datapath through scaling, averaging and curve lookup,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module bcle_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  bcle_pkg::bcle_status_t  status,
    output bcle_pkg::bcle_cmd_t     cmd
);
    import bcle_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL1  = 10'b00_0000_0010,
        ST_MUL2  = 10'b00_0000_0100,
        ST_RECIP = 10'b00_0000_1000,
        ST_CORR  = 10'b00_0001_0000,
        ST_AVG   = 10'b00_0010_0000,
        ST_LVL1  = 10'b00_0100_0000,
        ST_LVL2  = 10'b00_1000_0000,
        ST_LVL3  = 10'b01_0000_0000,
        ST_FIN   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && s_valid;
        cmd.mul1  = (state_reg == ST_MUL1);
        cmd.mul2  = (state_reg == ST_MUL2);
        cmd.recip = (state_reg == ST_RECIP);
        cmd.corr  = (state_reg == ST_CORR);
        cmd.avg   = (state_reg == ST_AVG);
        cmd.lvl1  = (state_reg == ST_LVL1);
        cmd.lvl2  = (state_reg == ST_LVL2);
        cmd.lvl3  = (state_reg == ST_LVL3);
        cmd.fin   = (state_reg == ST_FIN) && out_free;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_RECIP;
            ST_RECIP: state_next = ST_CORR;
            ST_CORR:  state_next = ST_AVG;
            // a failed reading leaves average and level alone
            ST_AVG:   state_next = status.reading_ok ? ST_LVL1 : ST_FIN;
            ST_LVL1:  state_next = ST_LVL2;
            ST_LVL2:  state_next = ST_LVL3;
            ST_LVL3:  state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hw/rtl/bcle_datapath.sv
// ----------------------------------------------------------------------------
// bcle_datapath
// Scaling, moving average, presence compare and piecewise-linear curve,
// one step per sequencer command.
// ----------------------------------------------------------------------------
module bcle_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bcle_pkg::bcle_cmd_t     cmd,
    input  bcle_pkg::bcle_cfg_t     cfg,
    input  bcle_pkg::bcle_in_t      s_data,
    output bcle_pkg::bcle_status_t  status,
    output bcle_pkg::bcle_out_t     m_data
);
    import bcle_pkg::*;

    // item and intermediate values
    bcle_in_t    in_reg;
    logic [14:0] prod1_reg;
    logic [25:0] prod2_reg;
    logic        sat_reg;
    logic [14:0] q0_reg;
    logic [14:0] scaled_reg;
    logic        ok_reg;
    logic [10:0] x_reg;
    logic [6:0]  base_reg;
    logic        cap_reg;
    logic [4:0]  iq_reg;
    bcle_out_t   out_reg;

    // persistent state
    logic [14:0] avg_reg, avg_next;
    logic        seeded_reg;
    logic        present_reg, present_next;
    logic [6:0]  level_reg, level_next;

    // scaling
    logic [14:0] prod1_next;
    logic [25:0] prod2_next;
    logic [50:0] recip_prod;
    logic [24:0] qm1000;
    logic [24:0] rem1000;
    logic [14:0] q_scaled;
    logic [14:0] scaled_next;

    // average
    logic signed [15:0] diff;
    logic signed [15:0] diff_adj;
    logic signed [15:0] avg_step;
    logic signed [15:0] avg_sum;

    // curve
    logic signed [16:0] v;
    logic [7:0]  seg_off;
    logic [6:0]  seg_plo;
    logic [3:0]  seg_slope;
    logic        seg_found;
    logic [10:0] x_next;
    logic [6:0]  base_next;
    logic signed [16:0] seg_diff;
    logic [20:0] iq_prod;
    logic [10:0] qm100;
    logic [10:0] rem100;
    logic [6:0]  pct;

    assign status.reading_ok = ok_reg;
    assign m_data            = out_reg;

    // ---- scaling ----
    assign prod1_next = {3'b0, in_reg.sense_mv} * {12'b0, cfg.divider_ratio};
    assign prod2_next = {11'b0, prod1_reg} * {15'b0, cfg.gain_trim_permille};
    // reciprocal estimate is exact or one low below the saturation limit
    assign recip_prod = {26'b0, prod2_reg[24:0]} * {25'b0, RECIP_1000};
    assign qm1000     = {10'b0, q0_reg} * 25'd1000;
    assign rem1000    = prod2_reg[24:0] - qm1000;
    assign q_scaled   = q0_reg + 15'(rem1000 >= 25'd1000);
    assign scaled_next = sat_reg ? AVG_MAX : q_scaled;

    // ---- moving average, quarter step truncated toward zero ----
    assign diff     = $signed({1'b0, scaled_reg}) - $signed({1'b0, avg_reg});
    assign diff_adj = diff + (diff[15] ? 16'sd3 : 16'sd0);
    assign avg_step = diff_adj >>> 2;
    assign avg_sum  = $signed({1'b0, avg_reg}) + avg_step;

    always_comb begin
        avg_next = avg_reg;
        if (ok_reg) begin
            avg_next = seeded_reg ? avg_sum[14:0] : scaled_reg;
        end
    end

    // ---- curve segment select ----
    assign v = $signed({2'b0, avg_reg})
             - $signed({9'b0, (in_reg.charging ? cfg.charge_offset_mv : 8'd0)});
    assign present_next = (avg_reg >= {2'b0, cfg.present_threshold_mv});

    always_comb begin
        seg_found = 1'b0;
        seg_off   = '0;
        seg_plo   = '0;
        seg_slope = '0;
        seg_diff  = '0;
        for (int i = 0; i < NUM_SEG; i++) begin
            if (!seg_found && (v >= $signed({4'b0, SEG_LO[i]}))) begin
                seg_found = 1'b1;
                seg_diff  = v - $signed({4'b0, SEG_LO[i]});
                seg_off   = seg_diff[7:0];
                seg_plo   = SEG_PLO[i];
                seg_slope = SEG_SLOPE[i];
            end
        end
    end

    always_comb begin
        x_next    = '0;
        base_next = PCT_EMPTY;
        priority if (!present_next || in_reg.charge_full) begin
            base_next = PCT_FULL;
        end else if (v >= $signed({4'b0, CURVE_TOP})) begin
            base_next = PCT_FULL;
        end else if (seg_found) begin
            base_next = seg_plo;
            x_next    = {3'b0, seg_off} * {7'b0, seg_slope};
        end else begin
            base_next = PCT_EMPTY;
        end
    end

    // ---- interpolation divide by 100 with one correction ----
    assign iq_prod = {10'b0, x_reg} * {11'b0, RECIP_100};
    assign qm100   = {6'b0, iq_reg} * 11'd100;
    assign rem100  = x_reg - qm100;
    assign pct     = base_reg + {2'b0, iq_reg} + 7'(rem100 >= 11'd100);
    // cap applies on the curve path only; an absent or full cell stays at 100
    assign level_next = (cap_reg && (pct > PCT_CHG_CAP)) ? PCT_CHG_CAP : pct;

    // ---- payload and intermediate registers ----
    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= s_data;
        if (cmd.mul1) prod1_reg <= prod1_next;
        if (cmd.mul2) prod2_reg <= prod2_next;
        if (cmd.recip) begin
            sat_reg <= (prod2_reg >= SAT_LIMIT);
            q0_reg  <= recip_prod[RECIP_SHIFT+14:RECIP_SHIFT];
        end
        if (cmd.corr) begin
            scaled_reg <= scaled_next;
            ok_reg     <= in_reg.sample_ok && (scaled_next != '0);
        end
        if (cmd.lvl1) begin
            x_reg    <= x_next;
            base_reg <= base_next;
            cap_reg  <= in_reg.charging && present_next && !in_reg.charge_full;
        end
        if (cmd.lvl2) iq_reg <= iq_prod[RECIP100_SH+4:RECIP100_SH];
        if (cmd.fin) begin
            out_reg.cell_present <= present_reg;
            out_reg.level_pct    <= level_reg;
            out_reg.average_mv   <= avg_reg;
        end
    end

    // ---- estimator state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg     <= '0;
            seeded_reg  <= 1'b0;
            present_reg <= 1'b0;
            level_reg   <= PCT_FULL;
        end else begin
            if (cmd.avg) begin
                avg_reg <= avg_next;
                if (ok_reg) begin
                    seeded_reg <= 1'b1;
                end else begin
                    present_reg <= 1'b0;
                end
            end
            if (cmd.lvl1) present_reg <= present_next;
            if (cmd.lvl3) level_reg   <= level_next;
        end
    end

endmodule

>>> hw/rtl/battery_charge_level_estimator_top.sv
// ----------------------------------------------------------------------------
// battery_charge_level_estimator_top
// Each poll transaction carries the sense-node millivolts, a sample-valid flag
// and the charger pins; the block scales the reading to cell millivolts, folds
// it into a quarter-weight moving average and returns presence, the state of
// charge from a 12-point curve and the average, one result per transaction.
// A sequencer steps a single datapath through two multiplies, a reciprocal
// divide by 1000, the average update, the curve select and a divide by 100 for
// interpolation; a failed or zero reading skips the curve steps. The result
// sits in an output register, so the next transaction is accepted while the
// previous result waits. Configuration writes are taken every cycle; unmapped
// indexes are dropped.
// ----------------------------------------------------------------------------
module battery_charge_level_estimator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bcle_pkg::bcle_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bcle_pkg::bcle_out_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcle_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcle_pkg::*;

    bcle_cfg_t    cfg;
    bcle_cmd_t    cmd;
    bcle_status_t status;

    bcle_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bcle_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_data  (s_data),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

>>> verif/battery_charge_level_estimator_top_test.sv
// ----------------------------------------------------------------------------
// battery_charge_level_estimator_top_test
// Self-checking bench for the charge level estimator. A short table of poll
// transactions covers the reading, charger and curve corners after reset.
// Random traffic then runs under several calibration settings, from the
// narrowest to beyond the register ranges. Every accepted poll goes through
// an in-bench model of the scaling, moving average and SoC curve, and each
// result transaction is checked against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module battery_charge_level_estimator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcle_pkg::*;

    localparam int unsigned RESET_CYCLES = 10;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam int unsigned LEVEL_FULL = 100;
    localparam int unsigned LEVEL_CHG_CAP = 99;
    localparam int unsigned KNEES = 12;
    localparam int KNEE_MV [KNEES] = '{
        4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300, 3200, 3000
    };
    localparam int KNEE_PCT [KNEES] = '{
        100, 90, 80, 70, 60, 45, 30, 18, 10, 5, 2, 0
    };

    typedef struct packed {
        bcle_in_t  poll;
        logic      typed;
        bcle_out_t report;
    } poll_row_t;

    // typed rows assume reset calibration: cell mV = sense * 1974 / 1000
    localparam int unsigned NUM_ROWS = 23;
    localparam poll_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{12'd100,  1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 7'd100, 15'd0}},
        '{'{12'd0,    1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 7'd100, 15'd0}},
        '{'{12'd4095, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b1, 7'd100, 15'd8083}},
        '{'{12'd4095, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 7'd99,  15'd8083}},
        '{'{12'd4095, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 7'd100, 15'd8083}},
        '{'{12'd4095, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 7'd100, 15'd8083}},
        '{'{12'd2128, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd2128, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{12'd1,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd1875, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd1875, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{12'd1773, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{12'd1672, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{12'd1520, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd1419, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd1418, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{12'd1000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd0,    1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{12'd2050, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{12'd4095, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd2432, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{12'd1365, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{12'd2730, 1'b1, 1'b0, 1'b0}, 1'b0, '0}
    };

    typedef enum int {
        RX_ALWAYS,
        RX_COIN_FLIP,
        RX_PERIODIC,
        RX_MOSTLY
    } rx_style_e;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    bcle_in_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    bcle_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // model of the block: calibration copy and estimator state
    bcle_cfg_t   cal_shadow = '{DIVIDER_RATIO_RST, GAIN_TRIM_RST, CHARGE_OFFSET_RST,
                                PRESENT_THRESHOLD_RST};
    logic [14:0] avg_mv_now = '0;
    logic        avg_seeded = 1'b0;
    logic        present_now = 1'b0;
    logic [6:0]  level_now = 7'd100;

    bcle_out_t   expected_reports [$];
    bcle_out_t   oldest_report;
    int unsigned mismatch_count = 0;

    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;
    rx_style_e   rx_style = RX_ALWAYS;

    battery_charge_level_estimator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // One poll tick: scale, fold into the average, derive presence and SoC.
    function automatic bcle_out_t estimate_poll(input bcle_in_t poll);
        longint unsigned scaled;
        int              diff;
        int              cell_mv;
        int unsigned     k;
        bcle_out_t       rpt;
        scaled = 64'(poll.sense_mv) * 64'(cal_shadow.divider_ratio)
                 * 64'(cal_shadow.gain_trim_permille) / 1000;
        if (scaled > 64'(AVG_MAX)) begin
            scaled = 64'(AVG_MAX);
        end
        if (!poll.sample_ok || scaled == 0) begin
            present_now = 1'b0;
        end else begin
            if (!avg_seeded) begin
                avg_mv_now = scaled[14:0];
                avg_seeded = 1'b1;
            end else begin
                diff = int'(scaled) - int'(avg_mv_now);
                avg_mv_now = 15'(int'(avg_mv_now) + diff / 4);
            end
            present_now = (avg_mv_now >= 15'(cal_shadow.present_threshold_mv));
            if (!present_now || poll.charge_full) begin
                level_now = 7'(LEVEL_FULL);
            end else begin
                cell_mv = int'(avg_mv_now);
                if (poll.charging) begin
                    cell_mv -= int'(cal_shadow.charge_offset_mv);
                end
                if (cell_mv >= KNEE_MV[0]) begin
                    level_now = 7'(LEVEL_FULL);
                end else if (cell_mv <= KNEE_MV[KNEES-1]) begin
                    level_now = 7'd0;
                end else begin
                    for (k = 1; k < KNEES; k++) begin
                        if (cell_mv >= KNEE_MV[k]) begin
                            level_now = 7'(KNEE_PCT[k] + (cell_mv - KNEE_MV[k])
                                * (KNEE_PCT[k-1] - KNEE_PCT[k]) / (KNEE_MV[k-1] - KNEE_MV[k]));
                            break;
                        end
                    end
                end
                if (poll.charging && level_now > 7'(LEVEL_CHG_CAP)) begin
                    level_now = 7'(LEVEL_CHG_CAP);
                end
            end
        end
        rpt.cell_present = present_now;
        rpt.level_pct = level_now;
        rpt.average_mv = avg_mv_now;
        return rpt;
    endfunction

    // Mostly readings aimed at the curve region, plus full-range, failed and corner ones.
    function automatic bcle_in_t draw_poll();
        bcle_in_t    poll;
        int unsigned pick;
        int unsigned gain;
        int unsigned target;
        pick = $urandom_range(0, 99);
        gain = int'(cal_shadow.divider_ratio) * int'(cal_shadow.gain_trim_permille);
        poll.sense_mv = 12'($urandom);
        poll.sample_ok = 1'b1;
        poll.charging = 1'($urandom);
        poll.charge_full = ($urandom_range(0, 3) == 0);
        if (pick < 55 && gain != 0) begin
            target = $urandom_range(2700, 4500);
            if (poll.charging) begin
                target += cal_shadow.charge_offset_mv;
            end
            target = target * 1000 / gain;
            poll.sense_mv = (target > 4095) ? 12'hFFF : 12'(target);
        end else if (pick < 75) begin
            poll.sample_ok = 1'b1;
        end else if (pick < 87) begin
            poll.sample_ok = 1'b0;
        end else if (pick < 95) begin
            case ($urandom_range(0, 3))
                0: poll.sense_mv = 12'd0;
                1: poll.sense_mv = 12'd1;
                2: poll.sense_mv = 12'hFFF;
                default: poll.sense_mv = 12'hFFE;
            endcase
        end else begin
            poll.sample_ok = 1'($urandom);
        end
        return poll;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction
    // with valid still high, so the caller either offers the next poll or drops it.
    task automatic send_poll(input bcle_in_t poll, input logic typed,
                             input bcle_out_t typed_report);
        bcle_out_t predicted;
        s_valid <= 1'b1;
        s_data <= poll;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = estimate_poll(poll);
        expected_reports.push_back(typed ? typed_report : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_reports.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Same write-valid rules as send_poll.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_DIVIDER_RATIO:     cal_shadow.divider_ratio = word[2:0];
            CFG_GAIN_TRIM:         cal_shadow.gain_trim_permille = word[10:0];
            CFG_CHARGE_OFFSET:     cal_shadow.charge_offset_mv = word[7:0];
            CFG_PRESENT_THRESHOLD: cal_shadow.present_threshold_mv = word[12:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Block idle first; unused high bits of each word carry junk.
    task automatic program_cal(input bcle_cfg_t cal);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(CFG_DIVIDER_RATIO, 16'({$urandom, cal.divider_ratio}));
        write_reg(CFG_GAIN_TRIM, 16'({$urandom, cal.gain_trim_permille}));
        write_reg(CFG_CHARGE_OFFSET, 16'({$urandom, cal.charge_offset_mv}));
        write_reg(CFG_PRESENT_THRESHOLD, 16'({$urandom, cal.present_threshold_mv}));
        // unmapped index, must be dropped
        write_reg(CFG_INDEX_W'($urandom_range(int'(CFG_PRESENT_THRESHOLD) + 1,
                                              (1 << CFG_INDEX_W) - 1)),
                  16'($urandom));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
                if (sent < count) begin
                    send_poll(draw_poll(), 1'b0, '0);
                    sent++;
                end
            end
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Result side back-pressure, plus long holds on request.
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) begin
            rx_style = rx_style_e'($urandom_range(0, 3));
        end
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:    m_ready <= 1'b1;
                RX_COIN_FLIP: m_ready <= 1'($urandom);
                RX_PERIODIC:  m_ready <= (rx_cycle % 5) < 2;
                default:      m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("result transaction with nothing pending: %p", m_data));
            end else begin
                oldest_report = expected_reports.pop_front();
                if (m_data.cell_present !== oldest_report.cell_present) begin
                    report_mismatch($sformatf("cell_present got %b want %b",
                        m_data.cell_present, oldest_report.cell_present));
                end
                if (m_data.level_pct !== oldest_report.level_pct) begin
                    report_mismatch($sformatf("level_pct got %0d want %0d",
                        m_data.level_pct, oldest_report.level_pct));
                end
                if (m_data.average_mv !== oldest_report.average_mv) begin
                    report_mismatch($sformatf("average_mv got %0d want %0d",
                        m_data.average_mv, oldest_report.average_mv));
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        bcle_cfg_t   cal;
        int unsigned row;
        int unsigned pass;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (row = 0; row < NUM_ROWS; row++) begin
            send_poll(DIRECTED_ROWS[row].poll, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].report);
        end
        s_valid <= 1'b0;

        // narrowest settings, and a long output stall with input still offered
        program_cal('{3'd1, 11'd900, 8'd0, 13'd0});
        hold_requests++;
        repeat (16) send_poll(draw_poll(), 1'b0, '0);
        s_valid <= 1'b0;
        run_phase(PHASE_ITEMS);

        program_cal('{3'd4, 11'd1100, 8'd255, 13'd8191});
        run_phase(PHASE_ITEMS);

        // beyond the stated ranges: scaling saturates
        program_cal('{3'd7, 11'd2047, 8'd255, 13'd8191});
        run_phase(120);

        // zero divider: every reading counts as failed
        program_cal('{3'd0, 11'd0, 8'd0, 13'd0});
        run_phase(30);

        for (pass = 0; pass < 3; pass++) begin
            cal.divider_ratio = 3'($urandom_range(1, 4));
            cal.gain_trim_permille = 11'($urandom_range(900, 1100));
            cal.charge_offset_mv = 8'($urandom);
            cal.present_threshold_mv = (pass == 2) ? 13'($urandom)
                                                   : 13'($urandom_range(2500, 3600));
            program_cal(cal);
            run_phase(PHASE_ITEMS);
        end

        program_cal('{DIVIDER_RATIO_RST, GAIN_TRIM_RST, CHARGE_OFFSET_RST,
                      PRESENT_THRESHOLD_RST});
        run_phase(PHASE_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
